@@ hw/rtl/kdps_pkg.sv @@
// ----------------------------------------------------------------------------
// kdps_pkg
// Shared types and constants for the keypad debounce priority scan block.
// ----------------------------------------------------------------------------
package kdps_pkg;

   localparam int NUM_BUTTONS_DEF = 10;
   localparam int RAW_W           = 10;
   localparam int MASK_W          = 10;
   localparam int INDEX_W         = 4;
   localparam int TIME_W          = 32;
   localparam int CFG_W           = 16;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd400;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

   // What one button lane reports to the merge stage.
   typedef struct packed {
      logic press;
      logic stable_old;
      logic stable_new;
      logic long_old;
      logic long_new;
   } lane_stat_type;

   typedef struct packed {
      logic               press_found;
      logic [INDEX_W-1:0] pressed_index;
      logic [MASK_W-1:0]  long_press_mask;
      logic [MASK_W-1:0]  stable_mask;
   } rsp_beat_type;

endpackage

@@ hw/rtl/kdps_lane.sv @@
// ----------------------------------------------------------------------------
// kdps_lane
// Debounce state and timer compares for one button.
// ----------------------------------------------------------------------------
module kdps_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan_en,
   input  logic                          visit,
   input  logic [kdps_pkg::TIME_W-1:0]   now_ms,
   input  logic                          raw,
   input  logic [kdps_pkg::CFG_W-1:0]    debounce_ms,
   input  logic [kdps_pkg::CFG_W-1:0]    long_press_ms,
   output kdps_pkg::lane_stat_type       stat
);

   logic                        raw_seen_ff;
   logic                        stable_ff;
   logic [kdps_pkg::TIME_W-1:0] raw_time_ff;
   logic [kdps_pkg::TIME_W-1:0] stable_time_ff;

   logic                        changed;
   logic                        accept;
   logic [kdps_pkg::TIME_W-1:0] raw_age;
   logic [kdps_pkg::TIME_W-1:0] stable_age;

   assign changed    = raw != raw_seen_ff;
   assign raw_age    = now_ms - raw_time_ff;
   assign stable_age = now_ms - stable_time_ff;

   // A fresh raw change is never accepted in the beat that sees it; its timer restarts.
   assign accept = !changed && (raw_age > kdps_pkg::TIME_W'(debounce_ms)) && (raw != stable_ff);

   always_comb begin
      stat.press      = accept && raw;
      stat.stable_old = stable_ff;
      stat.stable_new = accept ? raw : stable_ff;
      stat.long_old   = stable_ff && (stable_age >= kdps_pkg::TIME_W'(long_press_ms));
      stat.long_new   = accept ? (raw && (long_press_ms == '0)) : stat.long_old;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         raw_time_ff    <= '0;
         stable_time_ff <= '0;
      end else if (scan_en && visit) begin
         raw_seen_ff <= raw;
         if (changed) begin
            raw_time_ff <= now_ms;
         end
         if (accept) begin
            stable_ff      <= raw;
            stable_time_ff <= now_ms;
         end
      end
   end

endmodule

@@ hw/rtl/kdps_merge.sv @@
// ----------------------------------------------------------------------------
// kdps_merge
// Picks the first pressed lane and builds the visit mask and result masks.
// ----------------------------------------------------------------------------
module kdps_merge #(
   parameter int NUM_BUTTONS = kdps_pkg::NUM_BUTTONS_DEF
) (
   input  kdps_pkg::lane_stat_type [NUM_BUTTONS-1:0] stat,
   output logic [NUM_BUTTONS-1:0]                    visit,
   output kdps_pkg::rsp_beat_type                    beat
);

   logic [NUM_BUTTONS-1:0]       press;
   logic [NUM_BUTTONS-1:0]       first;
   logic [NUM_BUTTONS-1:0]       stable_all;
   logic [NUM_BUTTONS-1:0]       long_all;
   logic [kdps_pkg::INDEX_W-1:0] index;
   logic                         found;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         press[i] = stat[i].press;
      end
   end

   // Lowest set bit is the highest-priority press.
   assign first = press & (~press + NUM_BUTTONS'(1));
   assign found = |press;
   assign visit = found ? (first | (first - NUM_BUTTONS'(1))) : '1;

   always_comb begin
      index = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         index = index | (first[i] ? kdps_pkg::INDEX_W'(i) : '0);
         stable_all[i] = visit[i] ? stat[i].stable_new : stat[i].stable_old;
         long_all[i]   = visit[i] ? stat[i].long_new : stat[i].long_old;
      end
   end

   always_comb begin
      beat.press_found     = found;
      beat.pressed_index   = index;
      beat.long_press_mask = '0;
      beat.stable_mask     = '0;
      for (int b = 0; b < kdps_pkg::MASK_W; b++) begin
         if (b < NUM_BUTTONS) begin
            beat.long_press_mask[b] = long_all[b];
            beat.stable_mask[b]     = stable_all[b];
         end
      end
   end

endmodule

@@ hw/rtl/keypad_debounce_priority_scan.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_priority_scan
// Debounces a row of buttons, reports the first new press and long presses.
// ----------------------------------------------------------------------------
// Result beats are registered, in the skid while the output register stalls.
// Throughput: one scan beat per cycle while req_stall is low; all button
// lanes compare in parallel and a priority pick merges them in the same cycle.
// A two-entry output queue (output register plus skid) absorbs result stalls.
// Synchronous reset clears all button state and sets the default timings.
module keypad_debounce_priority_scan #(
   parameter int NUM_BUTTONS = kdps_pkg::NUM_BUTTONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kdps_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [kdps_pkg::RAW_W-1:0]    req_raw_levels,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_press_found,
   output logic [kdps_pkg::INDEX_W-1:0]  rsp_pressed_index,
   output logic [kdps_pkg::MASK_W-1:0]   rsp_long_press_mask,
   output logic [kdps_pkg::MASK_W-1:0]   rsp_stable_mask,
   input  logic                          csr_write_en,
   input  logic [0:0]                    csr_index,
   input  logic [kdps_pkg::CFG_W-1:0]    csr_write_data
);

   logic [kdps_pkg::CFG_W-1:0] debounce_ff, debounce_in;
   logic [kdps_pkg::CFG_W-1:0] long_press_ff, long_press_in;

   kdps_pkg::lane_stat_type [NUM_BUTTONS-1:0] stat;
   logic [NUM_BUTTONS-1:0]                    visit;
   kdps_pkg::rsp_beat_type                    beat;

   logic                   scan_en;
   logic                   out_take;
   logic                   rsp_valid_ff, rsp_valid_in;
   kdps_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   kdps_pkg::rsp_beat_type skid_data_ff, skid_data_in;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_write_en) begin
         unique case (kdps_pkg::csr_index_type'(csr_index))
            kdps_pkg::CSR_DEBOUNCE:   debounce_in   = csr_write_data;
            kdps_pkg::CSR_LONG_PRESS: long_press_in = csr_write_data;
            default:                  debounce_in   = debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= kdps_pkg::DEBOUNCE_RESET;
         long_press_ff <= kdps_pkg::LONG_PRESS_RESET;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
      end
   end

   assign req_stall = skid_valid_ff;
   assign scan_en   = req_valid && !skid_valid_ff;
   assign out_take  = rsp_valid_ff && !rsp_stall;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic raw_bit;
      if (i < kdps_pkg::RAW_W) begin : g_raw
         assign raw_bit = req_raw_levels[i];
      end else begin : g_zero
         assign raw_bit = 1'b0;
      end

      kdps_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .scan_en       (scan_en),
         .visit         (visit[i]),
         .now_ms        (req_now_ms),
         .raw           (raw_bit),
         .debounce_ms   (debounce_ff),
         .long_press_ms (long_press_ff),
         .stat          (stat[i])
      );
   end

   kdps_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .stat  (stat),
      .visit (visit),
      .beat  (beat)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = scan_en;
            rsp_data_in  = beat;
         end
      end else if (scan_en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_press_found     = rsp_data_ff.press_found;
   assign rsp_pressed_index   = rsp_data_ff.pressed_index;
   assign rsp_long_press_mask = rsp_data_ff.long_press_mask;
   assign rsp_stable_mask     = rsp_data_ff.stable_mask;

endmodule

@@ hw/rtl/kdps_checker.sv @@
// ----------------------------------------------------------------------------
// kdps_checker
// Port-level checks for the keypad debounce priority scan block.
// ----------------------------------------------------------------------------
module kdps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_press_found,
   input logic [kdps_pkg::INDEX_W-1:0]  rsp_pressed_index,
   input logic [kdps_pkg::MASK_W-1:0]   rsp_long_press_mask,
   input logic [kdps_pkg::MASK_W-1:0]   rsp_stable_mask
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressed_index)
         && $stable(rsp_stable_mask) && $stable(rsp_long_press_mask))
      else $error("stalled result beat changed");

   a_no_press_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_press_found |-> rsp_pressed_index == '0)
      else $error("index set without a press");

   a_press_is_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_found && (rsp_pressed_index < kdps_pkg::MASK_W)
         |-> rsp_stable_mask[rsp_pressed_index])
      else $error("reported press is not stable high");

   a_long_within_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_long_press_mask & ~rsp_stable_mask) == '0)
      else $error("long press on a released button");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind keypad_debounce_priority_scan kdps_checker u_kdps_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_press_found     (rsp_press_found),
   .rsp_pressed_index   (rsp_pressed_index),
   .rsp_long_press_mask (rsp_long_press_mask),
   .rsp_stable_mask     (rsp_stable_mask)
);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Keypad debounce priority scan testbench
// Drives timestamped scan beats into the block, predicts each result beat from
// a model of the per-button debounce timers, priority stop and long-press
// logic, and compares every result field by field under several timing
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
import kdps_pkg::*;

class keypad_scoreboard;
   localparam int BUTTONS = NUM_BUTTONS_DEF;

   logic [CFG_W-1:0]  debounce_limit;
   logic [CFG_W-1:0]  long_press_limit;
   logic              last_raw [BUTTONS];
   logic              settled [BUTTONS];
   logic [TIME_W-1:0] raw_edge_ms [BUTTONS];
   logic [TIME_W-1:0] settle_ms [BUTTONS];
   rsp_beat_type      expected_beats [$];
   int                error_count;

   function new();
      debounce_limit = DEBOUNCE_RESET;
      long_press_limit = LONG_PRESS_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
         last_raw[i] = 1'b0;
         settled[i] = 1'b0;
         raw_edge_ms[i] = '0;
         settle_ms[i] = '0;
      end
      error_count = 0;
   endfunction

   function void set_register(csr_index_type idx, logic [CFG_W-1:0] value);
      if (idx == CSR_DEBOUNCE) begin
         debounce_limit = value;
      end else begin
         long_press_limit = value;
      end
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction

   task report(string what);
      error_count++;
      if (error_count <= 100) begin
         $display("MISMATCH: %s", what);
      end
   endtask

   function void note_scan(logic [TIME_W-1:0] now, logic [RAW_W-1:0] raw);
      rsp_beat_type      beat;
      logic [TIME_W-1:0] elapsed;
      logic              level;
      bit                found;
      int                i;
      found = 0;
      beat = '0;
      for (i = 0; i < BUTTONS && !found; i++) begin
         level = (i < RAW_W) ? raw[i] : 1'b0;
         if (level != last_raw[i]) begin
            raw_edge_ms[i] = now;
            last_raw[i] = level;
         end
         elapsed = now - raw_edge_ms[i];
         if (elapsed > TIME_W'(debounce_limit) && level != settled[i]) begin
            settled[i] = level;
            settle_ms[i] = now;
            if (level) begin
               found = 1;
               beat.pressed_index = INDEX_W'(i);
            end
         end
      end
      beat.press_found = found;
      for (i = 0; i < BUTTONS && i < MASK_W; i++) begin
         if (settled[i]) begin
            beat.stable_mask[i] = 1'b1;
            elapsed = now - settle_ms[i];
            if (elapsed >= TIME_W'(long_press_limit)) begin
               beat.long_press_mask[i] = 1'b1;
            end
         end
      end
      expected_beats.push_back(beat);
   endfunction

   task check_result(rsp_beat_type got);
      rsp_beat_type want;
      if (expected_beats.size() == 0) begin
         report("result beat with no scan pending");
      end else begin
         want = expected_beats.pop_front();
         if (got.press_found !== want.press_found) begin
            report($sformatf("press_found got %0b expected %0b",
                             got.press_found, want.press_found));
         end
         if (got.pressed_index !== want.pressed_index) begin
            report($sformatf("pressed_index got %0d expected %0d",
                             got.pressed_index, want.pressed_index));
         end
         if (got.long_press_mask !== want.long_press_mask) begin
            report($sformatf("long_press_mask got %03h expected %03h",
                             got.long_press_mask, want.long_press_mask));
         end
         if (got.stable_mask !== want.stable_mask) begin
            report($sformatf("stable_mask got %03h expected %03h",
                             got.stable_mask, want.stable_mask));
         end
      end
   endtask
endclass

module testbench;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_SCANS = 310;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic [RAW_W-1:0]    req_raw_levels = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_press_found;
   logic [INDEX_W-1:0]  rsp_pressed_index;
   logic [MASK_W-1:0]   rsp_long_press_mask;
   logic [MASK_W-1:0]   rsp_stable_mask;
   logic                csr_write_en = 1'b0;
   logic [0:0]          csr_index = '0;
   logic [CFG_W-1:0]    csr_write_data = '0;

   keypad_scoreboard    scoreboard = new();
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  quiet_cycles = 0;
   logic [CFG_W-1:0]    debounce_set = DEBOUNCE_RESET;
   logic [CFG_W-1:0]    long_press_set = LONG_PRESS_RESET;
   logic [TIME_W-1:0]   scan_ms;
   logic [RAW_W-1:0]    scan_raw;

   keypad_debounce_priority_scan u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_now_ms          (req_now_ms),
      .req_raw_levels      (req_raw_levels),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_press_found     (rsp_press_found),
      .rsp_pressed_index   (rsp_pressed_index),
      .rsp_long_press_mask (rsp_long_press_mask),
      .rsp_stable_mask     (rsp_stable_mask),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            scoreboard.check_result({rsp_press_found, rsp_pressed_index,
                                     rsp_long_press_mask, rsp_stable_mask});
         end
         if (req_valid && !req_stall) begin
            scoreboard.note_scan(req_now_ms, req_raw_levels);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function int draw_gap(int pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < pct) begin
         gap++;
      end
      return gap;
   endfunction

   task send_scan(input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw);
      int gap;
      gap = draw_gap(send_idle_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_raw_levels <= raw;
      do @(posedge clock); while (req_stall);
   endtask

   task drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      scoreboard.set_register(idx, value);
      if (idx == CSR_DEBOUNCE) begin
         debounce_set = value;
      end else begin
         long_press_set = value;
      end
   endtask

   task run_directed();
      send_scan(32'd0, 10'h000);
      send_scan(32'd10, 10'h3FF);
      for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
         send_scan(32'd61 + i, 10'h3FF);
      end
      send_scan(32'd461, 10'h3FF);
      send_scan(32'd462, 10'h000);
      send_scan(32'd512, 10'h000);
      send_scan(32'd513, 10'h000);
      send_scan(32'hFFFF_FFF0, 10'h200);
      send_scan(32'h0000_0022, 10'h200);
      send_scan(32'h0000_0023, 10'h200);
      send_scan(32'h0000_0024, 10'h000);
      send_scan(32'h0000_0025, 10'h200);
      send_scan(32'h0000_0100, 10'h201);
   endtask

   task run_random(input int count, input int send_pct, input int recv_pct);
      logic [TIME_W-1:0] step;
      int                pick;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      scan_ms = ($urandom_range(3) == 0) ? 32'hFFFF_0000 + $urandom_range(65535)
                                         : $urandom();
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            scan_ms = $urandom();
            scan_raw = RAW_W'($urandom_range(1023));
         end else begin
            case ($urandom_range(5))
               0: step = '0;
               1: step = $urandom_range(3);
               2: step = TIME_W'(debounce_set) + $urandom_range(2);
               3: step = $urandom_range(0, debounce_set / 4 + 1);
               4: step = $urandom_range(0, long_press_set / 2 + 1);
               default: step = $urandom_range(0, 2 * debounce_set + 2);
            endcase
            scan_ms = scan_ms + step;
            if (pick < 28) begin
               scan_raw[$urandom_range(RAW_W - 1)] ^= 1'b1;
            end else if (pick < 32) begin
               scan_raw = RAW_W'($urandom_range(1023));
            end
         end
         send_scan(scan_ms, scan_raw);
      end
      drain();
   endtask

   initial begin
      scan_raw = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(PHASE_SCANS, 0, 0);
      write_csr(CSR_DEBOUNCE, 16'd0);
      write_csr(CSR_LONG_PRESS, 16'd0);
      run_random(PHASE_SCANS, 64, 0);
      write_csr(CSR_DEBOUNCE, 16'hFFFF);
      write_csr(CSR_LONG_PRESS, 16'hFFFF);
      run_random(PHASE_SCANS, 0, 64);
      write_csr(CSR_DEBOUNCE, CFG_W'($urandom_range(1, 200)));
      write_csr(CSR_LONG_PRESS, CFG_W'($urandom_range(0, 1000)));
      run_random(PHASE_SCANS, 31, 31);
      repeat (4) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
